// ===== rtl/pfe_pkg.sv =====
// Shared types, letter codes and square geometry helpers for the Playfair encryptor.
`timescale 1ns / 1ps

package pfe_pkg;

	typedef logic [4:0] letter_t;
	typedef logic [4:0] pos_t;
	typedef logic [2:0] coord_t;

	typedef struct packed {
		letter_t first;
		letter_t second;
	} pair_t;

	localparam logic [1:0] OP_KEY     = 2'd0;
	localparam logic [1:0] OP_KEY_END = 2'd1;
	localparam logic [1:0] OP_MSG     = 2'd2;
	localparam logic [1:0] OP_MSG_END = 2'd3;

	localparam letter_t CODE_I      = 5'd8;
	localparam letter_t CODE_J      = 5'd9;
	localparam letter_t CODE_X      = 5'd23;
	localparam letter_t LAST_LETTER = 5'd25;
	localparam pos_t    SQ_CELLS    = 5'd25;
	localparam coord_t  SQ_LAST     = 3'd4;

	localparam int ALPHA_N = 26;
	localparam int CELLS_N = 25;

	function automatic coord_t pos_row(input pos_t p);
		coord_t r;
		if (p >= 5'd20)      r = 3'd4;
		else if (p >= 5'd15) r = 3'd3;
		else if (p >= 5'd10) r = 3'd2;
		else if (p >= 5'd5)  r = 3'd1;
		else                 r = 3'd0;
		return r;
	endfunction

	function automatic coord_t pos_col(input pos_t p);
		coord_t r;
		pos_t   base;
		r    = pos_row(p);
		base = ({2'b00, r} << 2) + {2'b00, r};
		return 3'(p - base);
	endfunction

	function automatic pos_t pos_cell(input coord_t r, input coord_t c);
		return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
	endfunction

	function automatic coord_t wrap_inc(input coord_t v);
		return (v == SQ_LAST) ? 3'd0 : 3'(v + 3'd1);
	endfunction

endpackage

// ===== rtl/playfair_digraph_encrypt_top.sv =====
// Playfair encryptor top level: key square build, digraph sequencer and result buffer.
`timescale 1ns / 1ps

// Channel  Signals                         Dir  Moves
// in       in_valid in_ready op letter     in   one key or message request
// out      out_valid out_ready             out  one cipher letter
//          cipher_letter pair_end
//
// Key letters, message letters without a partner and ignored requests stay in S_IDLE.
// Key end runs S_FILL, one walk step per letter of the alphabet. A digraph steps S_RDA,
// S_RDB, S_CALC, S_RDQA, S_RDQB, S_OUT, set by two reads each through the single read port
// of the position and square RAMs; it then waits while the previous digraph is in the buffer.
// Reset clears the used bits, fill count, pending letter and the sequencer;
// both RAMs need no clearing. A stalled output blocks requests only once a
// second digraph is waiting behind a full result buffer.
module playfair_digraph_encrypt_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [4:0] letter,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] cipher_letter,
	output logic       pair_end
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FILL = 3'd1;
	localparam logic [2:0] S_RDA  = 3'd2;
	localparam logic [2:0] S_RDB  = 3'd3;
	localparam logic [2:0] S_CALC = 3'd4;
	localparam logic [2:0] S_RDQA = 3'd5;
	localparam logic [2:0] S_RDQB = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0]            state_q;
	logic [pfe_pkg::ALPHA_N-1:0] used_q;
	pfe_pkg::pos_t         fill_q;
	logic                  ready_q;
	pfe_pkg::letter_t      pend_q;
	logic                  pend_valid_q;
	pfe_pkg::letter_t      walk_q;
	pfe_pkg::letter_t      a_q;
	pfe_pkg::letter_t      b_q;
	pfe_pkg::pos_t         pa_q;
	pfe_pkg::pos_t         qa_q;
	pfe_pkg::pos_t         qb_q;
	pfe_pkg::letter_t      ca_q;

	logic                  accept;
	logic                  letter_ok;
	pfe_pkg::letter_t      folded;
	logic                  key_place;
	logic                  walk_place;
	logic                  wr_en;
	pfe_pkg::letter_t      wr_letter;
	logic                  pos_rd_en;
	pfe_pkg::letter_t      pos_rd_addr;
	pfe_pkg::pos_t         pos_rd_data;
	logic                  sq_rd_en;
	pfe_pkg::pos_t         sq_rd_addr;
	pfe_pkg::letter_t      sq_rd_data;
	pfe_pkg::coord_t       ra, ca, rb, cb;
	pfe_pkg::pos_t         qa_d, qb_d;
	logic                  ob_empty;
	logic                  ob_load;
	pfe_pkg::pair_t        ob_pair;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign letter_ok = (letter <= pfe_pkg::LAST_LETTER);
	assign folded    = (letter == pfe_pkg::CODE_J) ? pfe_pkg::CODE_I : letter;

	assign key_place = accept && (op == pfe_pkg::OP_KEY) && letter_ok && !ready_q
		&& !used_q[folded] && (fill_q < pfe_pkg::SQ_CELLS);
	assign walk_place = (state_q == S_FILL) && (walk_q != pfe_pkg::CODE_J)
		&& !used_q[walk_q] && (fill_q < pfe_pkg::SQ_CELLS);
	assign wr_en     = key_place || walk_place;
	assign wr_letter = (state_q == S_FILL) ? walk_q : folded;

	// Writes happen only before the square is ready and reads only after,
	// so the two RAMs never see a read and write of one entry overlap.
	pfe_ram #(.WIDTH(5), .DEPTH(pfe_pkg::ALPHA_N)) u_pos_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_letter),
		.wr_data (fill_q),
		.rd_en   (pos_rd_en),
		.rd_addr (pos_rd_addr),
		.rd_data (pos_rd_data)
	);

	pfe_ram #(.WIDTH(5), .DEPTH(pfe_pkg::CELLS_N)) u_sq_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q),
		.wr_data (wr_letter),
		.rd_en   (sq_rd_en),
		.rd_addr (sq_rd_addr),
		.rd_data (sq_rd_data)
	);

	assign pos_rd_en   = (state_q == S_RDA) || (state_q == S_RDB);
	assign pos_rd_addr = (state_q == S_RDA) ? a_q : b_q;
	assign sq_rd_en    = (state_q == S_RDQA) || (state_q == S_RDQB);
	assign sq_rd_addr  = (state_q == S_RDQA) ? qa_q : qb_q;

	always_comb begin
		ra = pfe_pkg::pos_row(pa_q);
		ca = pfe_pkg::pos_col(pa_q);
		rb = pfe_pkg::pos_row(pos_rd_data);
		cb = pfe_pkg::pos_col(pos_rd_data);
		if (ra == rb) begin
			qa_d = pfe_pkg::pos_cell(ra, pfe_pkg::wrap_inc(ca));
			qb_d = pfe_pkg::pos_cell(rb, pfe_pkg::wrap_inc(cb));
		end else if (ca == cb) begin
			qa_d = pfe_pkg::pos_cell(pfe_pkg::wrap_inc(ra), ca);
			qb_d = pfe_pkg::pos_cell(pfe_pkg::wrap_inc(rb), cb);
		end else begin
			qa_d = pfe_pkg::pos_cell(ra, cb);
			qb_d = pfe_pkg::pos_cell(rb, ca);
		end
	end

	assign ob_load        = (state_q == S_OUT) && ob_empty;
	assign ob_pair.first  = ca_q;
	assign ob_pair.second = sq_rd_data;

	pfe_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (ob_load),
		.pair          (ob_pair),
		.empty         (ob_empty),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cipher_letter (cipher_letter),
		.pair_end      (pair_end)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			fill_q       <= '0;
			ready_q      <= 1'b0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			walk_q       <= '0;
		end else begin
			if (wr_en) begin
				used_q[wr_letter] <= 1'b1;
				fill_q            <= 5'(fill_q + 5'd1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op)
							pfe_pkg::OP_KEY_END: begin
								if (!ready_q) begin
									walk_q  <= '0;
									state_q <= S_FILL;
								end
							end
							pfe_pkg::OP_MSG: begin
								if (letter_ok && ready_q) begin
									if (!pend_valid_q) begin
										pend_q       <= folded;
										pend_valid_q <= 1'b1;
									end else begin
										state_q <= S_RDA;
										if (folded != pend_q) begin
											pend_q       <= '0;
											pend_valid_q <= 1'b0;
										end
									end
								end
							end
							pfe_pkg::OP_MSG_END: begin
								if (ready_q && pend_valid_q) begin
									pend_q       <= '0;
									pend_valid_q <= 1'b0;
									state_q      <= S_RDA;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FILL: begin
					walk_q <= 5'(walk_q + 5'd1);
					if (walk_q == pfe_pkg::LAST_LETTER) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RDA:  state_q <= S_RDB;
				S_RDB:  state_q <= S_CALC;
				S_CALC: state_q <= S_RDQA;
				S_RDQA: state_q <= S_RDQB;
				S_RDQB: state_q <= S_OUT;
				S_OUT: begin
					if (ob_empty) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Digraph operands and intermediate positions.
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= pend_q;
			b_q <= ((op == pfe_pkg::OP_MSG_END) || (folded == pend_q))
				? pfe_pkg::CODE_X : folded;
		end
		if (state_q == S_CALC) begin
			qa_q <= qa_d;
			qb_q <= qb_d;
		end
		if (state_q == S_RDB) begin
			pa_q <= pos_rd_data;
		end
		if (state_q == S_RDQB) begin
			ca_q <= sq_rd_data;
		end
	end

	a_no_write_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !ready_q)
		else $error("square written after it was ready");

	a_lookup_needs_square: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDA) |-> ready_q)
		else $error("digraph lookup before square ready");

	a_walk_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) && (walk_q == pfe_pkg::LAST_LETTER)
		|=> ready_q && (fill_q == pfe_pkg::SQ_CELLS))
		else $error("square not full after key end walk");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= pfe_pkg::SQ_CELLS)
		else $error("fill count overflow");

endmodule

// ===== rtl/pfe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module pfe_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/pfe_outbuf.sv =====
// Two-entry result buffer that holds one digraph and hands it out letter by letter.
`timescale 1ns / 1ps

module pfe_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  pfe_pkg::pair_t  pair,
	output logic            empty,
	output logic            out_valid,
	input  logic            out_ready,
	output pfe_pkg::letter_t cipher_letter,
	output logic            pair_end
);

	logic [1:0]       cnt_q;
	pfe_pkg::letter_t first_q;
	pfe_pkg::letter_t second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= 2'd2;
		end else if (out_valid && out_ready) begin
			cnt_q <= 2'(cnt_q - 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			first_q  <= pair.first;
			second_q <= pair.second;
		end
	end

	assign empty         = (cnt_q == 2'd0);
	assign out_valid     = !empty;
	assign pair_end      = (cnt_q == 2'd1);
	assign cipher_letter = (cnt_q == 2'd2) ? first_q : second_q;

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> empty)
		else $error("digraph loaded over unsent results");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result count out of range");

endmodule
